[design/aes_rr_pkg.sv]
// shared types, constants and round functions for the reduced-round aes unit
// no dependencies; compiled first
package aes_rr_pkg;

  // configuration register indexes
  localparam logic CFG_ROUND_COUNT  = 1'b0;
  localparam logic CFG_FINAL_NO_MIX = 1'b1;

  // configuration reset values
  localparam logic [3:0] ROUND_COUNT_RST = 4'd10;
  localparam logic       FINAL_NO_MIX_RST = 1'b1;

  // input item modes
  localparam logic MODE_KEY_LOAD = 1'b0;
  localparam logic MODE_ENCRYPT  = 1'b1;

  localparam logic [7:0] BYTE_MASK = 8'hff;

  // forward s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } aes_rr_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // take a new block into the state register
    logic key_we;   // store the incoming key word
    logic step;     // advance the state by one round
    logic first;    // initial key addition only
    logic mix;      // apply mixcolumns in this round
    logic capture;  // copy the finished block to the output register
  } aes_rr_cmd_t;

  // multiply by x in gf(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    logic [7:0] d;
    d = {b[6:0], 1'b0} & BYTE_MASK;
    return b[7] ? (d ^ 8'h1b) : d;
  endfunction

  // subbytes on four bytes already gathered by shiftrows, then optional mixcolumns
  function automatic logic [31:0] round_column(input logic [7:0] s0, input logic [7:0] s1,
                                               input logic [7:0] s2, input logic [7:0] s3,
                                               input logic mix);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] b0, b1, b2, b3;
    a0 = SBOX[s0];
    a1 = SBOX[s1];
    a2 = SBOX[s2];
    a3 = SBOX[s3];
    if (mix) begin
      b0 = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
      b1 = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
      b2 = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
      b3 = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
    end else begin
      b0 = a0;
      b1 = a1;
      b2 = a2;
      b3 = a3;
    end
    return {b0, b1, b2, b3};
  endfunction

endpackage

[design/aes_rr_if.sv]
// valid/ready channel interfaces for the reduced-round aes unit
// no dependencies
interface aes_rr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  key_index;
  logic [31:0] key_word;
  logic [31:0] block_word0;
  logic [31:0] block_word1;
  logic [31:0] block_word2;
  logic [31:0] block_word3;

  modport source (
    output valid, mode, key_index, key_word,
           block_word0, block_word1, block_word2, block_word3,
    input  ready
  );
  modport sink (
    input  valid, mode, key_index, key_word,
           block_word0, block_word1, block_word2, block_word3,
    output ready
  );
endinterface

interface aes_rr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word0;
  logic [31:0] cipher_word1;
  logic [31:0] cipher_word2;
  logic [31:0] cipher_word3;

  modport source (
    output valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
    input  ready
  );
  modport sink (
    input  valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
    output ready
  );
endinterface

[design/aes_rr_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module aes_rr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/aes_rr_ctrl.sv]
// controller: configuration registers, round sequencer and output handshake
// depends on aes_rr_pkg
module aes_rr_ctrl #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [3:0]                         cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_mode,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output aes_rr_pkg::aes_rr_cmd_t            cmd,
  output logic [$clog2(MAX_ROUNDS+1)-1:0]    rd_addr
);
  import aes_rr_pkg::*;

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  aes_rr_state_t state_r, state_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic [3:0]    round_count_r;
  logic          final_no_mix_r;
  logic          out_valid_r, out_valid_nxt;
  logic [RW-1:0] last_round;
  logic          accept;
  logic          last;
  logic          stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r  <= ROUND_COUNT_RST;
      final_no_mix_r <= FINAL_NO_MIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROUND_COUNT:  round_count_r  <= cfg_wdata;
        CFG_FINAL_NO_MIX: final_no_mix_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // round count saturates at the largest supported value
  assign last_round = (round_count_r > 4'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS)
                                                       : round_count_r[RW-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = (round_r == last_round);
  assign stall    = last && out_valid_r && !out_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    cmd           = '0;
    rd_addr       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_ENCRYPT)) begin
          cmd.load  = 1'b1;
          round_nxt = '0;
          state_nxt = ST_RUN;
        end
        if (accept && (in_mode == MODE_KEY_LOAD)) begin
          cmd.key_we = 1'b1;
        end
      end
      ST_RUN: begin
        // fetch the next round's key row so it is ready when that round runs; hold the current one on the last round
        rd_addr   = last ? round_r : RW'(round_r + 1'b1);
        cmd.first = (round_r == '0);
        cmd.mix   = !(last && final_no_mix_r);
        if (!stall) begin
          cmd.step = 1'b1;
          if (last) begin
            cmd.capture   = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            round_nxt = RW'(round_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[design/aes_rr_dp.sv]
// datapath: round key banks, state register, shared round unit, output register
// depends on aes_rr_pkg and aes_rr_ram
module aes_rr_dp #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic                            clk,
  input  aes_rr_pkg::aes_rr_cmd_t         cmd,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0] rd_addr,
  input  logic [5:0]                      key_index,
  input  logic [31:0]                     key_word,
  input  logic [31:0]                     block_word0,
  input  logic [31:0]                     block_word1,
  input  logic [31:0]                     block_word2,
  input  logic [31:0]                     block_word3,
  output logic [31:0]                     cipher_word0,
  output logic [31:0]                     cipher_word1,
  output logic [31:0]                     cipher_word2,
  output logic [31:0]                     cipher_word3
);
  import aes_rr_pkg::*;

  localparam int KEY_ROWS  = MAX_ROUNDS + 1;
  localparam int KEY_DEPTH = 4 * KEY_ROWS;
  localparam int AW        = $clog2(KEY_ROWS);

  logic [31:0]   state_r   [4];
  logic [31:0]   state_nxt [4];
  logic [31:0]   cipher_r  [4];
  logic [31:0]   round_key [4];
  logic [31:0]   mixed     [4];
  logic          key_ok;
  logic [3:0]    key_row;

  // key words are striped over four banks by column, one row per round
  assign key_ok  = (key_index < 6'(KEY_DEPTH));
  assign key_row = key_index[5:2];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    aes_rr_ram #(
      .WIDTH (32),
      .DEPTH (KEY_ROWS)
    ) u_key_ram (
      .clk   (clk),
      .we    (cmd.key_we && key_ok && (key_index[1:0] == 2'(b))),
      .waddr (key_row[AW-1:0]),
      .wdata (key_word),
      .raddr (rd_addr),
      .rdata (round_key[b])
    );
  end

  // shiftrows wiring, subbytes and mixcolumns per column
  for (genvar c = 0; c < 4; c++) begin : g_col
    assign mixed[c] = round_column(state_r[c][31:24],
                                   state_r[(c + 1) % 4][23:16],
                                   state_r[(c + 2) % 4][15:8],
                                   state_r[(c + 3) % 4][7:0],
                                   cmd.mix);
    assign state_nxt[c] = (cmd.first ? state_r[c] : mixed[c]) ^ round_key[c];
  end

  // state register: loaded with the block, then one round per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state_r[0] <= block_word0;
      state_r[1] <= block_word1;
      state_r[2] <= block_word2;
      state_r[3] <= block_word3;
    end else if (cmd.step) begin
      for (int i = 0; i < 4; i++) begin
        state_r[i] <= state_nxt[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 4; i++) begin
        cipher_r[i] <= state_nxt[i];
      end
    end
  end

  assign cipher_word0 = cipher_r[0];
  assign cipher_word1 = cipher_r[1];
  assign cipher_word2 = cipher_r[2];
  assign cipher_word3 = cipher_r[3];

endmodule

[design/aes_reduced_round_encrypt_unit.sv]
// top level of the reduced-round aes encryption unit
// depends on aes_rr_pkg, aes_rr_if, aes_rr_ram, aes_rr_ctrl and aes_rr_dp

// A key-load beat (mode 0) writes one round key word in the cycle it is accepted and
// leaves the input ready, so a full schedule loads at one word per cycle while no
// block is in flight. An encrypt beat (mode 1) occupies the shared round unit for
// the initial key addition, then one round per step up to N, N being round_count
// saturated at MAX_ROUNDS, reading each key row from four column-wide key banks
// ahead of its round. The input is ready again once the result sits in the output
// register, so a new block is taken only after the previous one finishes, even
// while its result waits to be taken; a block that reaches its last round while
// that result is still waiting holds there until it is taken. Key words must be
// loaded before a block uses them. Configuration must be written only while no
// block is in flight; the unit does not hold off a write that arrives during a block.
module aes_reduced_round_encrypt_unit #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  aes_rr_in_if.sink   in_chan,
  aes_rr_out_if.source out_chan
);
  import aes_rr_pkg::*;

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  aes_rr_cmd_t   cmd;
  logic [RW-1:0] rd_addr;

  // sequencer and configuration
  aes_rr_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  // key store and round datapath
  aes_rr_dp #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .key_index    (in_chan.key_index),
    .key_word     (in_chan.key_word),
    .block_word0  (in_chan.block_word0),
    .block_word1  (in_chan.block_word1),
    .block_word2  (in_chan.block_word2),
    .block_word3  (in_chan.block_word3),
    .cipher_word0 (out_chan.cipher_word0),
    .cipher_word1 (out_chan.cipher_word1),
    .cipher_word2 (out_chan.cipher_word2),
    .cipher_word3 (out_chan.cipher_word3)
  );

endmodule

[design/aes_rr_chk.sv]
// port-level checker for the reduced-round aes unit, bound to the top level
// depends on aes_rr_pkg, aes_reduced_round_encrypt_unit and aes_rr_if
module aes_rr_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready
);
  import aes_rr_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  // an encrypt beat makes the unit busy
  a_encrypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_ENCRYPT) |=> !in_ready)
    else $error("encrypt beat did not occupy the round unit");

  // a key-load beat leaves the input ready
  a_key_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_KEY_LOAD) |=> in_ready)
    else $error("key load stalled the input");

  // a new result only appears at the end of a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a block in flight");

endmodule

bind aes_reduced_round_encrypt_unit aes_rr_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_mode   (in_chan.mode),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
